@@ sv/ssidx_pkg.sv @@
package ssidx_pkg;

  localparam int LEN_BITS = 16;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);
  localparam logic [7:0] NAME_LIMIT_RESET = 8'd32;
  localparam logic [LEN_BITS-1:0] MIN_ELEMENT_BYTES = LEN_BITS'(2);
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_FIRST = 8'h21;
  localparam logic [7:0] CH_LAST = 8'h7e;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic CFG_IDX_MAX_NAME = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID,
    PH_LEN,
    PH_EXTRACT,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       char_valid;
    logic       end_of_name;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

@@ sv/ssidx_parse.sv @@
module ssidx_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          start_of_buffer,
  input  logic [15:0]                   buffer_length,
  input  logic [7:0]                    max_name_length,
  input  logic                          room,
  output ssidx_pkg::push_t              push
);
  import ssidx_pkg::*;

  // input register
  logic                s1_v_r;
  logic [7:0]          s1_byte_r;
  logic                s1_start_r;
  logic [LEN_BITS-1:0] s1_len_r;

  // parse state
  logic [LEN_BITS-1:0] rem_r, rem_nxt;
  phase_t              ph_r, ph_nxt;
  logic [7:0]          id_r, id_nxt;
  logic [7:0]          elen_r, elen_nxt;
  logic [7:0]          pidx_r, pidx_nxt;

  logic                proc;
  logic [LEN_BITS-1:0] rem_w;
  phase_t              ph_w;
  logic [7:0]          id_w, elen_w, pidx_w;
  logic                active, finish, emit_char, printable;
  logic [7:0]          pidx_inc;

  assign proc = s1_v_r & room;
  assign in_ready = !s1_v_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_v_r <= 1'b1;
    end else if (proc) begin
      s1_v_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_byte_r  <= data_byte;
      s1_start_r <= start_of_buffer;
      s1_len_r   <= buffer_length[LEN_BITS-1:0];
    end
  end

  always_comb begin
    // a start byte reopens the buffer whatever phase we were in
    rem_w  = s1_start_r ? s1_len_r : rem_r;
    ph_w   = s1_start_r ? PH_ID : ph_r;
    id_w   = s1_start_r ? 8'd0 : id_r;
    elen_w = s1_start_r ? 8'd0 : elen_r;
    pidx_w = s1_start_r ? 8'd0 : pidx_r;

    rem_nxt   = rem_w;
    ph_nxt    = ph_w;
    id_nxt    = id_w;
    elen_nxt  = elen_w;
    pidx_nxt  = pidx_w;
    active    = 1'b1;
    finish    = 1'b0;
    emit_char = 1'b0;
    pidx_inc  = pidx_w + 8'd1;
    printable = (s1_byte_r >= CH_FIRST) && (s1_byte_r <= CH_LAST) &&
                (s1_byte_r != CH_BACKSLASH);

    case (ph_w)
      PH_ID: begin
        if (rem_w < MIN_ELEMENT_BYTES) begin
          finish = 1'b1;
        end else begin
          id_nxt  = s1_byte_r;
          rem_nxt = rem_w - LEN_BITS'(1);
          ph_nxt  = PH_LEN;
        end
      end
      PH_LEN: begin
        elen_nxt = s1_byte_r;
        // remaining count plus one is compared against the length byte alone
        if ({1'b0, rem_w} + (LEN_BITS+1)'(1) < (LEN_BITS+1)'(s1_byte_r)) begin
          finish = 1'b1;
        end else begin
          rem_nxt  = rem_w - LEN_BITS'(1);
          pidx_nxt = 8'd0;
          if (id_w == 8'd0 && s1_byte_r <= max_name_length) begin
            if (s1_byte_r == 8'd0) begin
              finish = 1'b1;
            end else begin
              ph_nxt = PH_EXTRACT;
            end
          end else begin
            ph_nxt = (s1_byte_r == 8'd0) ? PH_ID : PH_SKIP;
          end
        end
      end
      PH_EXTRACT: begin
        emit_char = printable ||
                    (s1_byte_r == CH_SPACE && pidx_w != 8'd0 && pidx_inc != elen_w);
        if (rem_w != '0) rem_nxt = rem_w - LEN_BITS'(1);
        pidx_nxt = pidx_inc;
        if (pidx_inc >= elen_w) finish = 1'b1;
      end
      PH_SKIP: begin
        if (rem_w != '0) rem_nxt = rem_w - LEN_BITS'(1);
        pidx_nxt = pidx_inc;
        if (pidx_inc >= elen_w) ph_nxt = PH_ID;
      end
      default: begin
        active = 1'b0;
      end
    endcase

    if (active && !finish && rem_nxt == '0) finish = 1'b1;
    if (active && finish) ph_nxt = PH_DONE;

    push.num = proc ? {1'b0, emit_char} + {1'b0, finish && active} : 2'd0;
    if (emit_char) begin
      push.r0 = '{name_char: s1_byte_r, char_valid: 1'b1, end_of_name: 1'b0};
    end else begin
      push.r0 = '{name_char: 8'd0, char_valid: 1'b0, end_of_name: 1'b1};
    end
    push.r1 = '{name_char: 8'd0, char_valid: 1'b0, end_of_name: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      ph_r   <= PH_IDLE;
      id_r   <= 8'd0;
      elen_r <= 8'd0;
      pidx_r <= 8'd0;
    end else if (proc) begin
      rem_r  <= rem_nxt;
      ph_r   <= ph_nxt;
      id_r   <= id_nxt;
      elen_r <= elen_nxt;
      pidx_r <= pidx_nxt;
    end
  end

endmodule

@@ sv/ssidx_outq.sv @@
module ssidx_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  ssidx_pkg::push_t    push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output ssidx_pkg::result_t  out_res,
  output logic [$clog2(ssidx_pkg::Q_DEPTH+1)-1:0] count
);
  import ssidx_pkg::*;

  result_t               mem_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_r, rd_r;
  logic [Q_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rd_r];
  // leave space for the two results one item can produce
  assign room      = cnt_r <= Q_CNT_BITS'(Q_DEPTH - 2);
  assign count     = cnt_r;
  assign cnt_nxt   = cnt_r + Q_CNT_BITS'(push.num) - Q_CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + Q_PTR_BITS'(push.num);
      rd_r  <= rd_r + Q_PTR_BITS'(pop);
      cnt_r <= cnt_nxt;
    end
    if (push.num != 2'd0) mem_r[wr_r] <= push.r0;
    if (push.num == 2'd2) mem_r[wr_r + Q_PTR_BITS'(1)] <= push.r1;
  end

endmodule

@@ sv/ssid_element_extractor.sv @@
// one transaction per cycle in when results drain at one per cycle; an item
// giving a character and an end marker produces two results
// a result passes from its input transaction through the input register,
// then parse logic into a 4-entry result queue
// synchronous active-low reset clears the parse state, the queue and sets
// max_name_length to 32
module ssid_element_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], buffer_length[23:8]
  input  logic [0:0]  in_tuser,   // start_of_buffer[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // name_char[7:0]
  output logic [0:0]  out_tuser,  // char_valid[0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ssidx_pkg::*;

  logic [7:0]            max_name_r;
  logic                  room;
  push_t                 push;
  result_t               out_res;
  logic [Q_CNT_BITS-1:0] q_count;
  logic                  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_MAX_NAME) ? {24'd0, max_name_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_name_r <= NAME_LIMIT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == CFG_IDX_MAX_NAME) begin
      max_name_r <= cfg_pwdata[7:0];
    end
  end

  ssidx_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .data_byte       (in_tdata[7:0]),
    .start_of_buffer (in_tuser[0]),
    .buffer_length   (in_tdata[23:8]),
    .max_name_length (max_name_r),
    .room            (room),
    .push            (push)
  );

  ssidx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .count     (q_count)
  );

  assign out_tdata    = out_res.name_char;
  assign out_tuser[0] = out_res.char_valid;
  assign out_tlast    = out_res.end_of_name;

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= Q_CNT_BITS'(Q_DEPTH))
    else $error("result queue overflow");

  a_char_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata >= CH_SPACE && out_tdata <= CH_LAST &&
    out_tdata != CH_BACKSLASH)
    else $error("non-printable name character");

  a_marker_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[0] != out_tlast)
    else $error("result is neither a character nor a bare end marker");

  // checked at the first edge out of reset, once the registers have been cleared
  a_ready_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_tready && !out_tvalid)
    else $error("not empty after reset");

endmodule

@@ test/ssid_checker.sv @@
module ssid_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], buffer_length[23:8]
  input  logic [0:0]  in_tuser,   // start_of_buffer[0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // name_char[7:0]
  input  logic [0:0]  out_tuser,  // char_valid[0]
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          mismatch_count,
  output int          awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import ssidx_pkg::*;

  localparam logic [2:0] NAME_LIMIT_ADDR = {CFG_IDX_MAX_NAME, 2'b00};

  result_t    name_results_q[$];
  logic [7:0] name_limit;
  logic [15:0] left;
  phase_t     phase;
  logic [7:0] ie_id;
  logic [7:0] ie_len;
  logic [7:0] ie_pos;

  function automatic bit is_name_char(logic [7:0] c, logic [7:0] pos, logic [7:0] len);
    if (c >= CH_FIRST && c <= CH_LAST && c != CH_BACKSLASH) return 1'b1;
    // a space counts only inside the name, never at either end
    return c == CH_SPACE && pos != 8'd0 && ({1'b0, pos} + 9'd1) != {1'b0, len};
  endfunction

  task automatic emit(logic [7:0] c, logic v, logic last);
    result_t r;
    r.name_char = c;
    r.char_valid = v;
    r.end_of_name = last;
    name_results_q.push_back(r);
  endtask

  task automatic parse_ie_byte(logic [7:0] b, logic start, logic [15:0] blen);
    bit done_now;
    done_now = 1'b0;
    if (start) begin
      left = blen;
      phase = PH_ID;
      ie_id = '0;
      ie_len = '0;
      ie_pos = '0;
    end
    case (phase)
      PH_ID: begin
        if (left < MIN_ELEMENT_BYTES) begin
          done_now = 1'b1;
        end else begin
          ie_id = b;
          left = left - 1'b1;
          phase = PH_LEN;
        end
      end
      PH_LEN: begin
        ie_len = b;
        // count still includes the length byte; it is compared, plus one, with the length alone
        if ({1'b0, left} + 17'd1 < {9'd0, b}) begin
          done_now = 1'b1;
        end else begin
          left = left - 1'b1;
          ie_pos = '0;
          if (ie_id == 8'd0 && b <= name_limit) begin
            if (b == 8'd0) done_now = 1'b1;
            else phase = PH_EXTRACT;
          end else if (b == 8'd0) begin
            phase = PH_ID;
          end else begin
            phase = PH_SKIP;
          end
        end
      end
      PH_EXTRACT: begin
        if (is_name_char(b, ie_pos, ie_len)) emit(b, 1'b1, 1'b0);
        if (left != 0) left = left - 1'b1;
        ie_pos = ie_pos + 1'b1;
        if (ie_pos >= ie_len) done_now = 1'b1;
      end
      PH_SKIP: begin
        if (left != 0) left = left - 1'b1;
        ie_pos = ie_pos + 1'b1;
        if (ie_pos >= ie_len) phase = PH_ID;
      end
      default: return;
    endcase
    if (!done_now && left == 0) done_now = 1'b1;
    if (done_now) begin
      emit(8'd0, 1'b0, 1'b1);
      phase = PH_DONE;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      name_limit = NAME_LIMIT_RESET;
      left = '0;
      phase = PH_IDLE;
      ie_id = '0;
      ie_len = '0;
      ie_pos = '0;
      name_results_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == NAME_LIMIT_ADDR) begin
        if (cfg_pwrite) begin
          name_limit = cfg_pwdata[7:0];
        end else if (cfg_prdata !== {24'd0, name_limit}) begin
          $display("%0t: name limit read, expected %h, got %h", $time,
                   {24'd0, name_limit}, cfg_prdata);
          mismatch_count++;
        end
      end
      if (in_tvalid && in_tready) parse_ie_byte(in_tdata[7:0], in_tuser[0], in_tdata[23:8]);
      if (out_tvalid && out_tready) begin
        if (name_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got char=%h valid=%b last=%b",
                   $time, out_tdata, out_tuser[0], out_tlast);
          mismatch_count++;
        end else begin
          want = name_results_q.pop_front();
          if (want.name_char !== out_tdata || want.char_valid !== out_tuser[0] ||
              want.end_of_name !== out_tlast) begin
            $display("%0t: expected char=%h valid=%b last=%b, got char=%h valid=%b last=%b",
                     $time, want.name_char, want.char_valid, want.end_of_name,
                     out_tdata, out_tuser[0], out_tlast);
            mismatch_count++;
          end
        end
      end
    end
    awaited_count = name_results_q.size();
  end

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssidx_pkg::*;

  typedef logic [7:0] ie_bytes_t[$];

  localparam logic [2:0] NAME_LIMIT_ADDR = {CFG_IDX_MAX_NAME, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [23:0] in_tdata = '0;   // data_byte[7:0], buffer_length[23:8]
  logic [0:0]  in_tuser = '0;   // start_of_buffer[0]
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [7:0]  out_tdata;       // name_char[7:0]
  wire  [0:0]  out_tuser;       // char_valid[0]
  wire         out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;
  int          mismatch_count;
  int          awaited_count;

  bit          steady = 1'b0;
  int          fed = 0;
  int          cur_limit = NAME_LIMIT_RESET;

  ssid_element_extractor dut (.*);
  ssid_checker chk (.*);

  initial forever #2 clk = ~clk;

  initial begin
    #400_000;
    $display("tb failed");
    $finish;
  end

  always @(negedge clk) out_tready <= steady || ($urandom_range(99) >= 14);

  task automatic push_byte(input logic [7:0] b, input logic st, input logic [15:0] blen);
    if (!steady && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {blen, b};
    in_tuser <= st;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_ie_buffer(input ie_bytes_t bq, input logic [15:0] blen, input int nsend);
    for (int i = 0; i < nsend; i++) push_byte(bq[i], i == 0, i == 0 ? blen : 16'($urandom));
    fed += nsend;
  endtask

  // stop feeding until every result is out and the pipeline has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= NAME_LIMIT_ADDR;
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [7:0] name_byte();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(8'h21, 8'h7e));
    if (r < 72) return CH_SPACE;
    if (r < 78) return CH_BACKSLASH;
    return 8'($urandom);
  endfunction

  task automatic add_element(inout ie_bytes_t bq, input logic [7:0] id, input int len,
                             input bit name_payload);
    bq.push_back(id);
    bq.push_back(8'(len));
    repeat (len) bq.push_back(name_payload ? name_byte() : 8'($urandom));
  endtask

  task automatic add_filler(inout ie_bytes_t bq, input int lim);
    // an id-0 element just over the limit must be skipped like any other
    if (lim < 20 && $urandom_range(4) == 0) add_element(bq, 8'd0, lim + 1, 1'b1);
    else add_element(bq, 8'($urandom_range(1, 255)), $urandom_range(0, 6), 1'b0);
  endtask

  task automatic build_ie_buffer(input int lim, output ie_bytes_t bq, output logic [15:0] blen,
                                 output int nsend);
    int size;
    int nlen;
    int mode;
    bq = {};
    repeat ($urandom_range(0, 2)) add_filler(bq, lim);
    if ($urandom_range(9) != 0) begin
      if ($urandom_range(99) < 80) nlen = $urandom_range(0, lim < 10 ? lim : 10);
      else nlen = lim <= 40 ? lim : $urandom_range(11, 40);
      add_element(bq, 8'd0, nlen, 1'b1);
    end
    repeat ($urandom_range(0, 2)) add_filler(bq, lim);
    if (bq.size() == 0) bq.push_back(8'($urandom));
    size = bq.size();
    mode = $urandom_range(99);
    nsend = size;
    if (mode < 70) begin
      blen = 16'(size);
    end else if (mode < 80) begin
      blen = 16'($urandom_range(1, size));
    end else if (mode < 90) begin
      // stated length beyond the bytes sent, the next buffer start cuts it
      blen = $urandom_range(1) ? 16'(size + $urandom_range(1, 4))
                               : 16'($urandom_range(size + 1, 65535));
    end else begin
      blen = 16'(size);
      nsend = $urandom_range(1, size);
    end
  endtask

  initial begin
    ie_bytes_t   bq;
    logic [15:0] blen;
    int          nsend;
    int          phase_end;
    logic [7:0]  limits [6];

    limits = '{8'd0, 8'd255, 8'd1, 8'($urandom), 8'd32, 8'($urandom_range(2, 40))};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero length: end marker only
    bq = '{8'h00};
    send_ie_buffer(bq, 16'd0, 1);
    // longest length, 0xff id with empty body, name with spaces at both ends
    bq = '{8'hff, 8'h00, 8'h00, 8'h03, 8'h20, 8'h41, 8'h20};
    send_ie_buffer(bq, 16'hffff, 7);
    // remaining count below the element length, then a stray byte
    bq = '{8'h00, 8'h07};
    send_ie_buffer(bq, 16'd4, 2);
    push_byte(8'h41, 1'b0, 16'hffff);
    // printable range edges, backslash, delete and an inner space
    bq = '{8'h00, 8'h06, 8'h5c, 8'h21, 8'h7e, 8'h7f, 8'h20, 8'h41};
    send_ie_buffer(bq, 16'd8, 8);
    // name element one over the limit, then restart mid buffer
    bq = '{8'h00, 8'h21, 8'h41};
    send_ie_buffer(bq, 16'd40, 3);
    // empty name element
    bq = '{8'h00, 8'h00, 8'h41};
    send_ie_buffer(bq, 16'd3, 3);
    // buffer runs out inside the name: last char and end marker together
    bq = '{8'h00, 8'h05, 8'h42, 8'h43, 8'h44};
    send_ie_buffer(bq, 16'd5, 5);

    for (int p = 0; p < 6; p++) begin
      settle();
      apb_access(1'b1, {24'($urandom), limits[p]});
      apb_access(1'b0, 32'($urandom));
      cur_limit = limits[p];
      steady = (p == 3);
      phase_end = fed + 155;
      while (fed < phase_end) begin
        build_ie_buffer(cur_limit, bq, blen, nsend);
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 16'($urandom));
        send_ie_buffer(bq, blen, nsend);
        if ($urandom_range(99) < 6) settle();
      end
    end
    steady = 1'b0;
    settle();

    if (mismatch_count == 0 && awaited_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
